// ===== rtl/tmcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the text console writer.
package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = COLUMNS * ROWS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // Field and bus widths
    localparam int KIND_W   = 2;
    localparam int GLYPH_W  = 8;
    localparam int ATTR_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int INDEX_W  = 11;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CELL_W   = $clog2(CELL_COUNT);
    localparam int DATA_W   = GLYPH_W + ATTR_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Character codes and reset colors
    localparam logic [GLYPH_W-1:0]  SPACE_CHAR   = 8'h20;
    localparam logic [GLYPH_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [NIBBLE_W-1:0] RESET_FG     = 4'hF;
    localparam logic [NIBBLE_W-1:0] RESET_BG     = 4'h0;

    // Register indexes (selected by paddr[2])
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_TAIL,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted item
        logic exec;        // simple put: write and move cursor
        logic walk_clr;    // restart the store walk at cell zero
        logic fill;        // write a blank at the walk address, advance
        logic fill_reset;  // blank uses the reset color
        logic move;        // read one row ahead of the walk, advance
        logic tail;        // finish a put after scrolling
        logic read;        // read the addressed cell
        logic out_load;    // load the result register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              need_scroll;
        logic              out_free;
        logic              fill_last;
        logic              move_last;
    } dp_stat_t;

endpackage

// ===== rtl/text_mode_console_writer.sv =====
// Top level: text console writer with APB color registers, controller and datapath.
//
// Usage: an item (kind, glyph, cell_index) enters on req_valid/req_ready and
// returns exactly one result (cursor_row_out, cursor_col_out, read_glyph,
// read_attr) on rsp_valid/rsp_ready, in order.
// Steps per item: a put that needs no scroll, and an unused kind, are accepted,
// then the store write and result load follow. A read adds one registered
// store read. A scroll walks the store (one read port, one write port), moving
// one cell a cycle, then blanks the last row. A clear fills one cell a cycle.
// Reset: the cursor goes to row 0, column 0, colors to white on black, and a
// clearing pass writes a space in the reset color into all CELL_COUNT (2000)
// cells, one a cycle; req_ready stays low during that pass.
// Stalls: the result register lets the next item be accepted while a result
// waits; a following result holds in the controller until rsp_ready frees it.
// Color registers (foreground at 0x0, background at 0x4) are written over APB.
// The user must write them only while the block is idle; the block itself does
// not enforce it. They apply to later writes and blanks.
module text_mode_console_writer
    import tmcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [GLYPH_W-1:0]  glyph,
    input  logic [INDEX_W-1:0]  cell_index,
    // result channel
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [ROW_W-1:0]    cursor_row_out,
    output logic [COL_W-1:0]    cursor_col_out,
    output logic [GLYPH_W-1:0]  read_glyph,
    output logic [ATTR_W-1:0]   read_attr,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [NIBBLE_W-1:0] fg_reg;
    logic [NIBBLE_W-1:0] bg_reg;
    logic                reg_sel;
    logic                reg_wr;
    dp_cmd_t             cmd;
    dp_stat_t            stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite;

    // Write color registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end
        else if (reg_wr)
        begin
            if (reg_sel == REG_FOREGROUND)
            begin
                fg_reg <= pwdata[NIBBLE_W-1:0];
            end
            else
            begin
                bg_reg <= pwdata[NIBBLE_W-1:0];
            end
        end
    end

    // Read back color registers
    assign prdata = (reg_sel == REG_BACKGROUND) ? PDATA_W'(bg_reg) : PDATA_W'(fg_reg);

    tmcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (kind),
        .glyph           (glyph),
        .cell_index      (cell_index),
        .text_foreground (fg_reg),
        .text_background (bg_reg),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .cursor_row_out  (cursor_row_out),
        .cursor_col_out  (cursor_col_out),
        .read_glyph      (read_glyph),
        .read_attr       (read_attr)
    );

endmodule

// ===== rtl/tmcw_ctrl.sv =====
// Controller state machine: sequences put, scroll, clear, read and the reset clearing pass.
module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (stat.kind)
                    KIND_PUT:
                    begin
                        if (stat.need_scroll)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_CLEAR: state_next = ST_CLEAR;
                    KIND_READ:  state_next = ST_RESP;
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SCROLL:
            begin
                if (stat.move_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_BLANK;
            ST_BLANK:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: state_next = ST_RESP;
            ST_CLEAR:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill       = 1'b1;
                cmd.fill_reset = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            ST_EXEC:
            begin
                case (stat.kind)
                    KIND_PUT:
                    begin
                        if (stat.need_scroll)
                        begin
                            cmd.walk_clr = 1'b1;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.exec     = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                    end
                    KIND_CLEAR: cmd.walk_clr = 1'b1;
                    KIND_READ:  cmd.read = 1'b1;
                    default:    cmd.out_load = stat.out_free;
                endcase
            end
            ST_SCROLL: cmd.move = 1'b1;
            ST_DRAIN:  cmd = '0;
            ST_BLANK:  cmd.fill = 1'b1;
            ST_TAIL:   cmd.tail = 1'b1;
            ST_CLEAR:  cmd.fill = 1'b1;
            ST_RESP:   cmd.out_load = stat.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== rtl/tmcw_datapath.sv =====
// Datapath: item registers, cursor, screen store, walk counter and result register.
module tmcw_datapath
    import tmcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [KIND_W-1:0]   kind,
    input  logic [GLYPH_W-1:0]  glyph,
    input  logic [INDEX_W-1:0]  cell_index,
    input  logic [NIBBLE_W-1:0] text_foreground,
    input  logic [NIBBLE_W-1:0] text_background,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [ROW_W-1:0]    cursor_row_out,
    output logic [COL_W-1:0]    cursor_col_out,
    output logic [GLYPH_W-1:0]  read_glyph,
    output logic [ATTR_W-1:0]   read_attr
);

    // Item registers
    logic [KIND_W-1:0]  kind_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    logic [INDEX_W-1:0] index_reg;

    // Cursor and walk
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CELL_W-1:0] walk_reg;
    logic [CELL_W-1:0] walk_next;

    // Store and move pipeline
    logic [DATA_W-1:0] mem [CELL_COUNT];
    logic [DATA_W-1:0] rd_data_reg;
    logic              read_ok_reg;
    logic              mv_pend_reg;
    logic [CELL_W-1:0] mv_dst_reg;

    // Result register
    logic               rsp_valid_reg;
    logic [ROW_W-1:0]   row_out_reg;
    logic [COL_W-1:0]   col_out_reg;
    logic [GLYPH_W-1:0] rglyph_reg;
    logic [ATTR_W-1:0]  rattr_reg;

    // Decode
    logic              is_nl;
    logic              wrap;
    logic              at_bottom;
    logic              index_ok;
    logic              out_free;
    logic [ATTR_W-1:0] cur_attr;
    logic [ROW_W-1:0]  row_eff;
    logic [COL_W-1:0]  col_eff;
    logic [CELL_W-1:0] put_addr;

    // Store ports
    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;

    assign is_nl     = (glyph_reg == NEWLINE_CHAR);
    assign wrap      = (32'(col_reg) >= COLUMNS);
    assign at_bottom = (32'(row_reg) == ROWS - 1);
    assign index_ok  = (32'(index_reg) < CELL_COUNT);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cur_attr  = {text_background, text_foreground};

    // Wrap moves the put to the start of the next row
    assign row_eff  = wrap ? ROW_W'(row_reg + 1'b1) : row_reg;
    assign col_eff  = wrap ? '0 : col_reg;
    assign put_addr = CELL_W'(32'(row_eff) * COLUMNS + 32'(col_eff));

    // Status
    assign stat.kind        = kind_reg;
    assign stat.need_scroll = (kind_reg == KIND_PUT) && at_bottom && (is_nl || wrap);
    assign stat.out_free    = out_free;
    assign stat.fill_last   = (walk_reg == CELL_W'(CELL_COUNT - 1));
    assign stat.move_last   = (walk_reg == CELL_W'(LAST_ROW_BASE - 1));

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg  <= kind;
            glyph_reg <= glyph;
            index_reg <= cell_index;
        end
    end

    // Compute the cursor after a simple put or a put after scrolling
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.exec)
        begin
            if (is_nl)
            begin
                row_next = ROW_W'(row_reg + 1'b1);
                col_next = '0;
            end
            else
            begin
                row_next = row_eff;
                col_next = COL_W'(col_eff + 1'b1);
            end
        end
        else if (cmd.tail)
        begin
            col_next = is_nl ? '0 : COL_W'(1);
        end
    end

    // Advance the walk
    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.walk_clr)
        begin
            walk_next = '0;
        end
        else if (cmd.fill || cmd.move)
        begin
            walk_next = CELL_W'(walk_reg + 1'b1);
        end
    end

    // Hold cursor, walk and move pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            walk_reg    <= '0;
            mv_pend_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            walk_reg    <= walk_next;
            mv_pend_reg <= cmd.move;
        end
    end

    // Select the store write: pending move, blank, put
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = walk_reg;
        wr_data = {cur_attr, SPACE_CHAR};
        if (mv_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = mv_dst_reg;
            wr_data = rd_data_reg;
        end
        else if (cmd.fill)
        begin
            wr_en   = 1'b1;
            wr_addr = walk_reg;
            wr_data = cmd.fill_reset ? {RESET_BG, RESET_FG, SPACE_CHAR}
                                     : {cur_attr, SPACE_CHAR};
        end
        else if (cmd.exec && !is_nl)
        begin
            wr_en   = 1'b1;
            wr_addr = put_addr;
            wr_data = {cur_attr, glyph_reg};
        end
        else if (cmd.tail && !is_nl)
        begin
            wr_en   = 1'b1;
            wr_addr = CELL_W'(LAST_ROW_BASE);
            wr_data = {cur_attr, glyph_reg};
        end
    end

    // Select the store read: one row ahead for a move, else the addressed cell
    assign rd_en   = cmd.move || cmd.read;
    assign rd_addr = cmd.move ? CELL_W'(32'(walk_reg) + COLUMNS)
                              : (index_ok ? CELL_W'(index_reg) : '0);

    // Store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Store read port and move destination
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.move)
        begin
            mv_dst_reg <= walk_reg;
        end
        if (cmd.read)
        begin
            read_ok_reg <= index_ok;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            row_out_reg <= row_next;
            col_out_reg <= col_next;
            if ((kind_reg == KIND_READ) && read_ok_reg)
            begin
                rglyph_reg <= rd_data_reg[GLYPH_W-1:0];
                rattr_reg  <= rd_data_reg[DATA_W-1:GLYPH_W];
            end
            else
            begin
                rglyph_reg <= '0;
                rattr_reg  <= '0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign cursor_row_out = row_out_reg;
    assign cursor_col_out = col_out_reg;
    assign read_glyph     = rglyph_reg;
    assign read_attr      = rattr_reg;

`ifndef NO_ASSERTIONS
    // A pending move owns the write port
    assert property (@(posedge clk) disable iff (!rst_n)
        mv_pend_reg |-> !(cmd.fill || cmd.exec || cmd.tail))
        else $error("store write collides with pending move");

    // Cursor stays on screen, or one column past the end of a row before a wrap
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) <= ROWS - 1) && (32'(col_reg) <= COLUMNS))
        else $error("cursor off screen");

    // Result loads only into a free register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten before taken");

    // A simple put writes inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !is_nl) |-> (32'(put_addr) < CELL_COUNT))
        else $error("put address out of range");
`endif

endmodule

// ===== test/console_check_pkg.sv =====
// Screen shadow and result scoreboard used by the text console writer bench.
package console_check_pkg;
    import tmcw_pkg::*;

    // One result item as the block reports it
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GLYPH_W-1:0] glyph;
        logic [ATTR_W-1:0]  attr;
    } cursor_report_t;

    class console_shadow;
        logic [GLYPH_W-1:0]  cell_glyph [CELL_COUNT];
        logic [ATTR_W-1:0]   cell_attr  [CELL_COUNT];
        int                  row;
        int                  col;
        logic [NIBBLE_W-1:0] fg;
        logic [NIBBLE_W-1:0] bg;
        cursor_report_t      awaited [$];
        int                  mismatches;

        // Start from the reset screen: spaces in the reset color, cursor home
        function new();
            fg         = RESET_FG;
            bg         = RESET_BG;
            row        = 0;
            col        = 0;
            mismatches = 0;
            wipe_screen();
        endfunction

        function void blank_row(int r);
            for (int i = 0; i < COLUMNS; i++)
            begin
                cell_glyph[r * COLUMNS + i] = SPACE_CHAR;
                cell_attr[r * COLUMNS + i]  = {bg, fg};
            end
        endfunction

        function void wipe_screen();
            for (int r = 0; r < ROWS; r++)
                blank_row(r);
        endfunction

        // Go to column zero of the next row, scrolling on the bottom row
        function void line_feed();
            col = 0;
            if (row < ROWS - 1)
                row++;
            else
            begin
                for (int i = 0; i < LAST_ROW_BASE; i++)
                begin
                    cell_glyph[i] = cell_glyph[i + COLUMNS];
                    cell_attr[i]  = cell_attr[i + COLUMNS];
                end
                blank_row(ROWS - 1);
            end
        endfunction

        function void set_color(logic sel, logic [NIBBLE_W-1:0] value);
            if (sel == REG_FOREGROUND)
                fg = value;
            else
                bg = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted item and queue the cursor report it causes
        function void log_item(logic [KIND_W-1:0] k, logic [GLYPH_W-1:0] g,
                               logic [INDEX_W-1:0] idx);
            cursor_report_t want;
            int             addr;
            want = '0;
            if (k == KIND_PUT)
            begin
                if (g == NEWLINE_CHAR)
                    line_feed();
                else
                begin
                    // full column wraps before the write
                    if (col >= COLUMNS)
                        line_feed();
                    addr             = row * COLUMNS + col;
                    cell_glyph[addr] = g;
                    cell_attr[addr]  = {bg, fg};
                    col++;
                end
            end
            else if (k == KIND_CLEAR)
                wipe_screen();
            else if (k == KIND_READ && idx < CELL_COUNT)
            begin
                want.glyph = cell_glyph[idx];
                want.attr  = cell_attr[idx];
            end
            want.row = ROW_W'(row);
            want.col = COL_W'(col);
            awaited.push_back(want);
        endfunction

        // Compare a result with the oldest queued report
        function void match_result(cursor_report_t got);
            cursor_report_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row=%0d col=%0d glyph=%h attr=%h",
                             got.row, got.col, got.glyph, got.attr);
                return;
            end
            want = awaited.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.glyph !== want.glyph || got.attr !== want.attr)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected row=%0d col=%0d glyph=%h attr=%h,",
                              " got row=%0d col=%0d glyph=%h attr=%h"},
                             want.row, want.col, want.glyph, want.attr,
                             got.row, got.col, got.glyph, got.attr);
            end
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
// Bench top: drives items and color writes into the console writer and checks every result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tmcw_pkg::*;
    import console_check_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_PHASE_ITEMS = 300;
    localparam int CALM_ITEMS         = 100;
    localparam int DRAIN_LIMIT        = 50000;
    localparam int SETTLE_CYCLES      = 64;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                req_valid  = 1'b0;
    logic                req_ready;
    logic [KIND_W-1:0]   kind       = '0;
    logic [GLYPH_W-1:0]  glyph      = '0;
    logic [INDEX_W-1:0]  cell_index = '0;
    logic                rsp_valid;
    logic                rsp_ready  = 1'b0;
    logic [ROW_W-1:0]    cursor_row_out;
    logic [COL_W-1:0]    cursor_col_out;
    logic [GLYPH_W-1:0]  read_glyph;
    logic [ATTR_W-1:0]   read_attr;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    console_shadow shadow;
    int            items_sent = 0;
    int            gap_odds   = 0;
    int            stall_odds = 0;
    int            stall_left = 0;

    text_mode_console_writer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .kind           (kind),
        .glyph          (glyph),
        .cell_index     (cell_index),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .read_glyph     (read_glyph),
        .read_attr      (read_attr),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check accepted results and stall the result side in bursts
    always @(posedge clk)
    begin : result_monitor
        cursor_report_t seen;
        if (rsp_valid && rsp_ready)
        begin
            seen.row   = cursor_row_out;
            seen.col   = cursor_col_out;
            seen.glyph = read_glyph;
            seen.attr  = read_attr;
            shadow.match_result(seen);
        end
        if (stall_left > 0)
            stall_left--;
        else if (stall_odds > 0 && $urandom_range(0, 399) < stall_odds)
            stall_left = $urandom_range(1, 11);
        rsp_ready <= (stall_left == 0);
    end

    // Offer one item, hold it until accepted, then maybe idle
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [GLYPH_W-1:0] g,
                             input logic [INDEX_W-1:0] idx);
        req_valid  <= 1'b1;
        kind       <= k;
        glyph      <= g;
        cell_index <= idx;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.log_item(k, g, idx);
        items_sent++;
        if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Drop the item valid and wait until every queued report has come back
    task automatic wait_drained();
        int waited;
        waited    = 0;
        req_valid <= 1'b0;
        while (shadow.pending() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Write one color nibble over APB; upper data bits are noise
    task automatic write_color(input logic sel, input logic [NIBBLE_W-1:0] nib);
        logic [PDATA_W-1:0] word;
        word              = $urandom;
        word[NIBBLE_W-1:0] = nib;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_color(sel, nib);
        // return to idle so the next transfer starts on its own edge
        @(posedge clk);
    endtask

    // Mostly text lines and reads near the cursor, with some noise
    task automatic run_random_phase(input int count);
        int                 target;
        int                 pick;
        int                 len;
        logic [INDEX_W-1:0] idx;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // a line of text, sometimes long enough to wrap
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90)
                                                  : $urandom_range(0, 40);
                repeat (len)
                    send_item(KIND_PUT, GLYPH_W'($urandom), INDEX_W'($urandom));
                if ($urandom_range(0, 3) != 0)
                    send_item(KIND_PUT, NEWLINE_CHAR, INDEX_W'($urandom));
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0:       idx = INDEX_W'(shadow.row * COLUMNS
                                                + $urandom_range(0, COLUMNS - 1));
                        1:       idx = INDEX_W'(LAST_ROW_BASE + $urandom_range(0, COLUMNS - 1));
                        2:       idx = INDEX_W'(CELL_COUNT - 2 + $urandom_range(0, 3));
                        default: idx = INDEX_W'($urandom);
                    endcase
                    send_item(KIND_READ, GLYPH_W'($urandom), idx);
                end
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(KIND_PUT, NEWLINE_CHAR, INDEX_W'($urandom));
            end
            else if (pick < 93)
                send_item(KIND_CLEAR, GLYPH_W'($urandom), INDEX_W'($urandom));
            else
                send_item(KIND_W'($urandom), GLYPH_W'($urandom), INDEX_W'($urandom));
        end
    endtask

    initial
    begin
        shadow = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: glyph extremes, reads in and out of range, unused kind, clear
        send_item(KIND_PUT, 8'h00, '0);
        send_item(KIND_PUT, 8'hFF, '0);
        send_item(KIND_PUT, SPACE_CHAR, '0);
        send_item(KIND_PUT, 8'h41, '1);
        send_item(KIND_READ, '0, INDEX_W'(0));
        send_item(KIND_READ, '0, INDEX_W'(1));
        send_item(KIND_READ, '1, INDEX_W'(3));
        send_item(KIND_PUT, NEWLINE_CHAR, '0);
        send_item(KIND_READ, '0, INDEX_W'(4));
        send_item(KIND_READ, '0, INDEX_W'(CELL_COUNT - 1));
        send_item(KIND_READ, '0, INDEX_W'(CELL_COUNT));
        send_item(KIND_READ, '0, '1);
        send_item(KIND_UNUSED, '1, '1);
        send_item(KIND_UNUSED, '0, '0);
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_READ, '0, INDEX_W'(0));
        send_item(KIND_PUT, 8'h7E, '0);
        send_item(KIND_READ, '0, INDEX_W'(COLUMNS));
        send_item(KIND_PUT, NEWLINE_CHAR, '0);

        // Random phases, each under its own colors and idling
        wait_drained();
        write_color(REG_FOREGROUND, 4'h0);
        write_color(REG_BACKGROUND, 4'h0);
        gap_odds   = 20;
        stall_odds = 20;
        run_random_phase(RANDOM_PHASE_ITEMS);

        wait_drained();
        write_color(REG_FOREGROUND, 4'hF);
        write_color(REG_BACKGROUND, 4'hF);
        gap_odds   = 0;
        stall_odds = 0;
        run_random_phase(RANDOM_PHASE_ITEMS);

        wait_drained();
        write_color(REG_BACKGROUND, NIBBLE_W'($urandom));
        write_color(REG_FOREGROUND, NIBBLE_W'($urandom));
        gap_odds   = 40;
        stall_odds = 40;
        run_random_phase(RANDOM_PHASE_ITEMS);

        wait_drained();
        write_color(REG_FOREGROUND, 4'h0);
        write_color(REG_BACKGROUND, 4'hF);
        gap_odds   = 10;
        stall_odds = 30;
        run_random_phase(RANDOM_PHASE_ITEMS);

        // Last part runs with no idling on either side
        wait_drained();
        write_color(REG_FOREGROUND, NIBBLE_W'($urandom));
        write_color(REG_BACKGROUND, NIBBLE_W'($urandom));
        gap_odds   = 0;
        stall_odds = 0;
        run_random_phase(CALM_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog well past the slowest legal run
    initial
    begin
        #80_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
